FILE: rtl/msr_pkg.sv
// Shared types and constants for the motor speed ramp block.
// Defines the command word, the result word and reset values; no dependencies.
package msr_pkg;

    localparam int SPEED_W    = 9;
    localparam int DUTY_W     = 8;
    localparam int INTERVAL_W = 16;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;

    localparam logic [DUTY_W-1:0]     SPEED_LIMIT_RESET = 8'd102;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET    = 16'd1;

    // item modes carried in tuser
    localparam logic MODE_COMMAND = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    typedef struct packed {
        logic                         mode;
        logic signed [SPEED_W-1:0]    target_speed;
        logic        [INTERVAL_W-1:0] step_interval;
    } item_t;

    typedef struct packed {
        logic              limit_hit;
        logic              ramping;
        logic              going_forward;
        logic [DUTY_W-1:0] reverse_duty;
        logic [DUTY_W-1:0] forward_duty;
    } result_t;

endpackage

FILE: rtl/motor_speed_ramp_with_direction.sv
// Top level of the motor speed ramp: stream ports, input and result registers.
// Depends on msr_pkg and msr_ramp_core.
// An accepted word goes from the input register to the result register, then m_axis.
// Throughput: one word per cycle unless m_axis_tready holds the result register;
// the ramp state updates in a single pass as a word leaves the input register.
// Reset (aresetn, synchronous, active low): speed, goal and tick count to 0,
// interval to 1, limit to 102, both stages empty.
module motor_speed_ramp_with_direction (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [7:0]                      cfg_wr_data,   // speed_limit
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [8:0] target_speed, [24:9] step_interval, zero fill
    input  logic [msr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tuser,  // mode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] forward_duty, [15:8] reverse_duty, [16] going_forward,
    // [17] ramping, [18] limit_hit, zero fill
    output logic [msr_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import msr_pkg::*;

    logic [DUTY_W-1:0] limit_reg;
    logic              in_valid_reg;
    item_t             in_item_reg;
    logic              out_valid_reg;
    result_t           out_result_reg;
    result_t           core_result;
    logic              advance;

    // move a word forward when the result slot is free or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // hold the speed limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= SPEED_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_item_reg.mode          <= s_axis_tuser;
            in_item_reg.target_speed  <= s_axis_tdata[SPEED_W-1:0];
            in_item_reg.step_interval <= s_axis_tdata[SPEED_W+INTERVAL_W-1:SPEED_W];
        end
    end

    msr_ramp_core u_core (
        .clk         (aclk),
        .rstn        (aresetn),
        .step_en     (advance),
        .item        (in_item_reg),
        .speed_limit (limit_reg),
        .result      (core_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - $bits(result_t)){1'b0}}, out_result_reg};

endmodule

FILE: rtl/msr_ramp_core.sv
// Ramp state and one-pass update: clamp, tick counting, unit step, duty split.
// Depends on msr_pkg.
module msr_ramp_core (
    input  logic                            clk,
    input  logic                            rstn,
    input  logic                            step_en,
    input  msr_pkg::item_t                  item,
    input  logic [msr_pkg::DUTY_W-1:0]      speed_limit,
    output msr_pkg::result_t                result
);
    import msr_pkg::*;

    logic signed [SPEED_W-1:0]    current_reg, current_next;
    logic signed [SPEED_W-1:0]    goal_reg, goal_next;
    logic        [INTERVAL_W-1:0] interval_reg, interval_next;
    logic        [INTERVAL_W-1:0] tick_reg, tick_next;
    logic                         clamp_reg, clamp_next;

    logic signed [SPEED_W:0]      target_ext;
    logic signed [SPEED_W:0]      lim_pos;
    logic signed [SPEED_W:0]      lim_neg;
    logic        [INTERVAL_W-1:0] tick_inc;
    logic signed [SPEED_W-1:0]    speed_mag;

    // clamp bounds widened so the full target range compares cleanly
    assign target_ext = {item.target_speed[SPEED_W-1], item.target_speed};
    assign lim_pos    = $signed({2'b00, speed_limit});
    assign lim_neg    = -lim_pos;
    assign tick_inc   = tick_reg + 1'b1;

    // next state for one word
    always_comb begin
        current_next  = current_reg;
        goal_next     = goal_reg;
        interval_next = interval_reg;
        tick_next     = tick_reg;
        clamp_next    = clamp_reg;
        if (item.mode == MODE_COMMAND) begin
            tick_next     = '0;
            interval_next = (item.step_interval == '0) ? INTERVAL_RESET : item.step_interval;
            if (target_ext > lim_pos) begin
                goal_next  = lim_pos[SPEED_W-1:0];
                clamp_next = 1'b1;
            end else if (target_ext < lim_neg) begin
                goal_next  = lim_neg[SPEED_W-1:0];
                clamp_next = 1'b1;
            end else begin
                goal_next  = item.target_speed;
                clamp_next = 1'b0;
            end
        end else if (current_reg != goal_reg) begin
            tick_next = tick_inc;
            if (tick_inc >= interval_reg) begin
                tick_next    = '0;
                current_next = (current_reg < goal_reg) ? current_reg + SPEED_W'(1)
                                                        : current_reg - SPEED_W'(1);
            end
        end else begin
            tick_next = '0;
        end
    end

    // advance state on an accepted word
    always_ff @(posedge clk) begin
        if (!rstn) begin
            current_reg  <= '0;
            goal_reg     <= '0;
            interval_reg <= INTERVAL_RESET;
            tick_reg     <= '0;
            clamp_reg    <= 1'b0;
        end else if (step_en) begin
            current_reg  <= current_next;
            goal_reg     <= goal_next;
            interval_reg <= interval_next;
            tick_reg     <= tick_next;
            clamp_reg    <= clamp_next;
        end
    end

    // split signed speed into per-direction duty
    assign speed_mag = -current_next;
    always_comb begin
        result.going_forward = ~current_next[SPEED_W-1];
        result.forward_duty  = current_next[SPEED_W-1] ? '0 : current_next[DUTY_W-1:0];
        result.reverse_duty  = current_next[SPEED_W-1] ? speed_mag[DUTY_W-1:0] : '0;
        result.ramping       = (current_next != goal_next);
        result.limit_hit     = clamp_next;
    end

    // speed moves at most one unit per word
    a_unit_step: assert property (@(posedge clk) disable iff (!rstn)
        1'b1 |=> ((current_reg - $past(current_reg)) == 0
               || (current_reg - $past(current_reg)) == 1
               || (current_reg - $past(current_reg)) == -1))
        else $error("speed jumped by more than one unit");

    // a command never moves the speed
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rstn)
        (step_en && item.mode == MODE_COMMAND) |=> $stable(current_reg))
        else $error("speed changed on a command word");

    // tick count stays below the interval
    a_tick_bound: assert property (@(posedge clk) disable iff (!rstn)
        (tick_reg == '0) || (tick_reg < interval_reg))
        else $error("tick count reached interval without a step");

    // at most one direction has nonzero duty
    a_one_dir: assert property (@(posedge clk) disable iff (!rstn)
        (result.forward_duty == '0) || (result.reverse_duty == '0))
        else $error("both duties active");

endmodule
